// ----- hw/rtl/hpd_pkg.sv -----
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared types, codes and helpers for the palette and hold-and-modify
// pixel decoder.
// ----------------------------------------------------------------------------
package hpd_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int RGB_W         = 24;

	localparam logic       CMD_WRITE = 1'b0;
	localparam logic       CMD_PIXEL = 1'b1;

	localparam logic       CFG_MODE   = 1'b0;
	localparam logic       CFG_PLANES = 1'b1;

	localparam logic [1:0] MODE_INDEXED = 2'd0;
	localparam logic [1:0] MODE_HAM6    = 2'd1;
	localparam logic [1:0] MODE_HAM8    = 2'd2;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_BLUE  = 2'd1;
	localparam logic [1:0] ACT_RED   = 2'd2;
	localparam logic [1:0] ACT_GREEN = 2'd3;

	localparam logic [1:0] CFG_MODE_RESET   = MODE_INDEXED;
	localparam logic [3:0] CFG_PLANES_RESET = 4'd8;

	typedef struct packed {
		logic       first;
		logic       load;
		logic       oor;
		logic       ham8;
		logic [1:0] action;
		logic [5:0] data;
	} pix_info_t;

	function automatic logic [7:0] plane_mask(input logic [3:0] planes);
		logic [8:0] ones;
		ones = (9'd1 << planes[2:0]) - 9'd1;
		if (planes >= 4'd8) begin
			return 8'hff;
		end
		return ones[7:0];
	endfunction

endpackage

// ----- hw/rtl/hpd_ram.sv -----
// ----------------------------------------------------------------------------
// hpd_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module hpd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hw/rtl/hpd_lookup.sv -----
// ----------------------------------------------------------------------------
// hpd_lookup
// Input stage: configuration registers, code decode, palette address and
// palette memory. Carries each pixel into the first pipeline stage.
// ----------------------------------------------------------------------------
module hpd_lookup #(
	parameter int PALETTE_DEPTH = hpd_pkg::PALETTE_DEPTH,
	localparam int AW           = $clog2(PALETTE_DEPTH)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic                       cfg_index,
	input  logic [3:0]                 cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	input  logic                       first_in_row,
	input  logic [7:0]                 colour_code,
	input  logic [7:0]                 palette_index,
	input  logic [7:0]                 palette_red,
	input  logic [7:0]                 palette_green,
	input  logic [7:0]                 palette_blue,
	input  logic                       s1_ready,
	output logic                       valid_s1,
	output hpd_pkg::pix_info_t         info_s1,
	output logic [hpd_pkg::RGB_W-1:0]  entry_s1
);

	logic [1:0]         mode_q;
	logic [3:0]         planes_q;
	logic               ham;
	logic               accept;
	logic [7:0]         idx;
	logic [7:0]         raddr_full;
	logic               wr_en;
	logic               rd_en;
	hpd_pkg::pix_info_t info;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= hpd_pkg::CFG_MODE_RESET;
			planes_q <= hpd_pkg::CFG_PLANES_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == hpd_pkg::CFG_MODE) begin
				mode_q <= cfg_data[1:0];
			end else begin
				planes_q <= cfg_data;
			end
		end
	end

	assign in_ready = !valid_s1 || s1_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		ham         = (mode_q == hpd_pkg::MODE_HAM6) || (mode_q == hpd_pkg::MODE_HAM8);
		info.first  = first_in_row;
		info.ham8   = (mode_q == hpd_pkg::MODE_HAM8);
		info.action = info.ham8 ? colour_code[7:6] : colour_code[5:4];
		info.data   = info.ham8 ? colour_code[5:0] : {2'b00, colour_code[3:0]};
		info.load   = !ham || (info.action == hpd_pkg::ACT_LOAD);
		idx         = ham ? {2'b00, info.data}
		                  : (colour_code & hpd_pkg::plane_mask(planes_q));
		raddr_full  = info.load ? idx : 8'd0;
		info.oor    = ({1'b0, raddr_full} >= 9'(PALETTE_DEPTH));
	end

	assign wr_en = accept && (command == hpd_pkg::CMD_WRITE)
	               && ({1'b0, palette_index} < 9'(PALETTE_DEPTH));
	assign rd_en = accept && (command == hpd_pkg::CMD_PIXEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			info_s1 <= info;
		end
	end

	hpd_ram #(
		.WIDTH (hpd_pkg::RGB_W),
		.DEPTH (PALETTE_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (wr_en),
		.waddr (palette_index[AW-1:0]),
		.wdata ({palette_red, palette_green, palette_blue}),
		.re    (rd_en),
		.raddr (raddr_full[AW-1:0]),
		.rdata (entry_s1)
	);

endmodule

// ----- hw/rtl/hpd_colour.sv -----
// ----------------------------------------------------------------------------
// hpd_colour
// Result stage: applies the row start and the hold-and-modify step to the
// held colour and drives the output register.
// ----------------------------------------------------------------------------
module hpd_colour (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      valid_s1,
	input  hpd_pkg::pix_info_t        info_s1,
	input  logic [hpd_pkg::RGB_W-1:0] entry_s1,
	output logic                      s1_ready,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                red,
	output logic [7:0]                green,
	output logic [7:0]                blue
);

	logic [hpd_pkg::RGB_W-1:0] held_q;
	logic [hpd_pkg::RGB_W-1:0] entry;
	logic [hpd_pkg::RGB_W-1:0] base;
	logic [hpd_pkg::RGB_W-1:0] res;
	logic [7:0]                chan;
	logic [7:0]                modified;
	logic                      take;

	always_comb begin
		entry = info_s1.oor ? '0 : entry_s1;
		base  = info_s1.first ? entry : held_q;
		case (info_s1.action)
			hpd_pkg::ACT_BLUE:  chan = base[7:0];
			hpd_pkg::ACT_RED:   chan = base[23:16];
			default:            chan = base[15:8];
		endcase
		modified = info_s1.ham8 ? {info_s1.data, chan[1:0]}
		                        : {info_s1.data[3:0], chan[3:0]};
		res = base;
		if (info_s1.load) begin
			res = entry;
		end else begin
			case (info_s1.action)
				hpd_pkg::ACT_BLUE:  res[7:0]   = modified;
				hpd_pkg::ACT_RED:   res[23:16] = modified;
				hpd_pkg::ACT_GREEN: res[15:8]  = modified;
				default:            res        = base;
			endcase
		end
	end

	assign s1_ready = !out_valid || out_ready;
	assign take     = valid_s1 && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				held_q    <= res;
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			red   <= res[23:16];
			green <= res[15:8];
			blue  <= res[7:0];
		end
	end

endmodule

// ----- hw/rtl/ham_palette_pixel_decoder.sv -----
// ----------------------------------------------------------------------------
// ham_palette_pixel_decoder
// Palette and hold-and-modify pixel decoder: one transaction per clock
// unless out_ready holds off the output. An accepted pixel passes the palette
// read register and then the output register; a stall can hold it between.
// The palette memory has a single read port.
// Reset clears the held colour and the pipeline valid flags and returns the
// configuration registers to their reset values. The palette memory is not
// cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module ham_palette_pixel_decoder #(
	parameter int PALETTE_DEPTH = hpd_pkg::PALETTE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       command,
	input  logic       first_in_row,
	input  logic [7:0] colour_code,
	input  logic [7:0] palette_index,
	input  logic [7:0] palette_red,
	input  logic [7:0] palette_green,
	input  logic [7:0] palette_blue,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);

	logic                      s1_ready;
	logic                      valid_s1;
	hpd_pkg::pix_info_t        info_s1;
	logic [hpd_pkg::RGB_W-1:0] entry_s1;

	hpd_lookup #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_lookup (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.command       (command),
		.first_in_row  (first_in_row),
		.colour_code   (colour_code),
		.palette_index (palette_index),
		.palette_red   (palette_red),
		.palette_green (palette_green),
		.palette_blue  (palette_blue),
		.s1_ready      (s1_ready),
		.valid_s1      (valid_s1),
		.info_s1       (info_s1),
		.entry_s1      (entry_s1)
	);

	hpd_colour u_colour (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.info_s1   (info_s1),
		.entry_s1  (entry_s1),
		.s1_ready  (s1_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the palette and hold-and-modify pixel decoder.
// The bench loads palette entries and decodes pixels in plain indexed, HAM6
// and HAM8 modes. It keeps its own copy of the palette, the held colour and
// the mode registers, and works out the colour of each accepted pixel. The
// result is checked channel by channel against the decoder output. A short
// directed sequence comes first, followed by random rows of pixels under
// several register settings. Both handshake sides insert random gaps, and
// one long output hold-off backs the decoder up.
// ----------------------------------------------------------------------------
module testbench;

	localparam int PHASE_ITEMS  = 118;
	localparam int HOLD_CYCLES  = 300;
	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 10;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic       command;
		logic       first;
		logic [7:0] code;
		logic [7:0] idx;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pix_item_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	logic       clk;
	logic       arst_n        = 1'b0;
	logic       cfg_valid     = 1'b0;
	logic       cfg_ready;
	logic       cfg_index     = hpd_pkg::CFG_MODE;
	logic [3:0] cfg_data      = 4'd0;
	logic       in_valid      = 1'b0;
	logic       in_ready;
	logic       command       = hpd_pkg::CMD_WRITE;
	logic       first_in_row  = 1'b0;
	logic [7:0] colour_code   = 8'd0;
	logic [7:0] palette_index = 8'd0;
	logic [7:0] palette_red   = 8'd0;
	logic [7:0] palette_green = 8'd0;
	logic [7:0] palette_blue  = 8'd0;
	logic       out_valid;
	logic       out_ready     = 1'b0;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	pix_item_t   pending_items[$];
	rgb_t        rgb_expected[$];
	pix_item_t   cur_item;
	rgb_t        got_rgb;
	rgb_t        want_rgb;

	logic [23:0] palette_shadow[hpd_pkg::PALETTE_DEPTH];
	logic [23:0] held_rgb   = '0;
	logic [1:0]  mode_cfg   = hpd_pkg::CFG_MODE_RESET;
	logic [3:0]  planes_cfg = hpd_pkg::CFG_PLANES_RESET;

	bit          gen_written[hpd_pkg::PALETTE_DEPTH];
	logic [1:0]  gen_mode   = hpd_pkg::CFG_MODE_RESET;
	logic [3:0]  gen_planes = hpd_pkg::CFG_PLANES_RESET;

	int          items_queued   = 0;
	int          items_accepted = 0;
	int          mismatches     = 0;
	int          gap_left       = 0;
	int          stall_left     = 0;
	int          quiet_cycles   = 0;
	int          hold_req       = 0;
	int          hold_ack       = 0;
	bit          in_idle_on     = 1'b1;
	bit          out_stall_on   = 1'b1;

	ham_palette_pixel_decoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.first_in_row (first_in_row),
		.colour_code  (colour_code),
		.palette_index(palette_index),
		.palette_red  (palette_red),
		.palette_green(palette_green),
		.palette_blue (palette_blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red          (red),
		.green        (green),
		.blue         (blue)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [7:0] index_mask(input logic [3:0] planes);
		logic [8:0] ones;
		ones = (9'd1 << planes) - 9'd1;
		return (planes >= 4'd8) ? 8'hff : ones[7:0];
	endfunction

	function automatic int draw_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 85) begin
			return $urandom_range(3, 1);
		end else if (roll < 97) begin
			return $urandom_range(12, 4);
		end
		return $urandom_range(60, 20);
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t: mismatch on %s: got %02h, expected %02h", $time, what, got, want);
		mismatches++;
	endtask

	task automatic decode_pixel(input pix_item_t it);
		logic [7:0] r, g, b, data, keep;
		logic [1:0] act;
		int         shift;
		if (it.command == hpd_pkg::CMD_WRITE) begin
			palette_shadow[it.idx] = {it.r, it.g, it.b};
			return;
		end
		if (it.first) begin
			held_rgb = palette_shadow[0];
		end
		{r, g, b} = held_rgb;
		if (mode_cfg == hpd_pkg::MODE_HAM6 || mode_cfg == hpd_pkg::MODE_HAM8) begin
			if (mode_cfg == hpd_pkg::MODE_HAM8) begin
				act   = it.code[7:6];
				data  = {2'b00, it.code[5:0]};
				keep  = 8'h03;
				shift = 2;
			end else begin
				act   = it.code[5:4];
				data  = {4'b0000, it.code[3:0]};
				keep  = 8'h0f;
				shift = 4;
			end
			case (act)
				hpd_pkg::ACT_LOAD: begin
					{r, g, b} = palette_shadow[data];
				end
				hpd_pkg::ACT_BLUE: begin
					b = (b & keep) | (data << shift);
				end
				hpd_pkg::ACT_RED: begin
					r = (r & keep) | (data << shift);
				end
				default: begin
					g = (g & keep) | (data << shift);
				end
			endcase
		end else begin
			{r, g, b} = palette_shadow[it.code & index_mask(planes_cfg)];
		end
		held_rgb = {r, g, b};
		rgb_expected.push_back({r, g, b});
	endtask

	function automatic bit code_readable(input logic [7:0] c);
		if (gen_mode == hpd_pkg::MODE_HAM8) begin
			return (c[7:6] != hpd_pkg::ACT_LOAD) || gen_written[{2'b00, c[5:0]}];
		end else if (gen_mode == hpd_pkg::MODE_HAM6) begin
			return (c[5:4] != hpd_pkg::ACT_LOAD) || gen_written[{4'b0000, c[3:0]}];
		end
		return gen_written[c & index_mask(gen_planes)];
	endfunction

	function automatic logic [7:0] pick_code();
		logic [7:0] c;
		for (int i = 0; i < 32; i++) begin
			c = 8'($urandom_range(255));
			if (code_readable(c)) begin
				return c;
			end
		end
		return 8'h00;
	endfunction

	task automatic push_write(input logic [7:0] idx, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b, input logic first,
			input logic [7:0] code);
		pending_items.push_back({hpd_pkg::CMD_WRITE, first, code, idx, r, g, b});
		gen_written[idx] = 1'b1;
		items_queued++;
	endtask

	task automatic push_pixel(input logic first, input logic [7:0] code);
		pix_item_t it;
		it         = pix_item_t'($urandom());
		it.command = hpd_pkg::CMD_PIXEL;
		it.first   = first;
		it.code    = code;
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic push_random_write();
		int         roll;
		logic [7:0] idx;
		roll = $urandom_range(9);
		if (roll < 5) begin
			idx = 8'($urandom_range(15));
		end else if (roll < 8) begin
			idx = 8'($urandom_range(63));
		end else begin
			idx = 8'($urandom_range(255));
		end
		push_write(idx, 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 1'($urandom_range(1)), 8'($urandom_range(255)));
	endtask

	task automatic wait_idle();
		while (items_accepted != items_queued || rgb_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [3:0] value);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == hpd_pkg::CFG_MODE) begin
			mode_cfg = value[1:0];
		end else begin
			planes_cfg = value;
		end
	endtask

	task automatic apply_setting(input logic [1:0] mode, input logic [3:0] planes);
		wait_idle();
		write_reg(hpd_pkg::CFG_MODE, {2'b00, mode});
		write_reg(hpd_pkg::CFG_PLANES, planes);
		gen_mode   = mode;
		gen_planes = planes;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && in_ready) begin
				decode_pixel(cur_item);
				items_accepted++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left--;
				end else if (pending_items.size() > 0) begin
					cur_item = pending_items.pop_front();
					in_valid      <= 1'b1;
					command       <= cur_item.command;
					first_in_row  <= cur_item.first;
					colour_code   <= cur_item.code;
					palette_index <= cur_item.idx;
					palette_red   <= cur_item.r;
					palette_green <= cur_item.g;
					palette_blue  <= cur_item.b;
					gap_left = in_idle_on ? draw_gap() : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && out_ready) begin
				got_rgb = {red, green, blue};
				if (rgb_expected.size() == 0) begin
					report_mismatch("unexpected pixel red", got_rgb.r, 8'h00);
				end else begin
					want_rgb = rgb_expected.pop_front();
					if (got_rgb.r !== want_rgb.r) begin
						report_mismatch("red", got_rgb.r, want_rgb.r);
					end
					if (got_rgb.g !== want_rgb.g) begin
						report_mismatch("green", got_rgb.g, want_rgb.g);
					end
					if (got_rgb.b !== want_rgb.b) begin
						report_mismatch("blue", got_rgb.b, want_rgb.b);
					end
				end
			end
			if (hold_req != hold_ack) begin
				hold_ack   = hold_req;
				stall_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (out_stall_on && $urandom_range(5) == 0) begin
					stall_left = draw_gap();
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)
					|| (cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [1:0] phase_mode[11];
		logic [3:0] phase_planes[11];
		int         row_left;
		bit         first;
		phase_mode   = '{hpd_pkg::MODE_HAM6, hpd_pkg::MODE_HAM8, hpd_pkg::MODE_INDEXED,
			MODE_UNUSED, hpd_pkg::MODE_HAM8, hpd_pkg::MODE_HAM6, hpd_pkg::MODE_INDEXED,
			hpd_pkg::MODE_HAM8, hpd_pkg::MODE_HAM6, hpd_pkg::MODE_INDEXED,
			hpd_pkg::MODE_HAM8};
		phase_planes = '{4'd8, 4'd1, 4'd0, 4'd5, 4'd8, 4'd3, 4'd15, 4'd0, 4'd7, 4'd4, 4'd12};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Indexed mode at reset settings, all eight planes in use.
		push_write(8'd0, 8'h12, 8'h34, 8'h56, 1'b1, 8'hff);
		push_write(8'd255, 8'hff, 8'hff, 8'hff, 1'b0, 8'h00);
		push_write(8'd15, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00);
		push_write(8'd63, 8'ha5, 8'h5a, 8'hc3, 1'b0, 8'hff);
		push_write(8'd1, 8'h80, 8'h7f, 8'h01, 1'b0, 8'h5a);
		push_pixel(1'b0, 8'hff);
		push_pixel(1'b0, 8'h0f);
		push_pixel(1'b1, 8'h3f);
		push_pixel(1'b0, 8'h00);

		// HAM6: row start, each modify, a palette write that must leave the
		// held colour alone, and upper code bits that are ignored.
		apply_setting(hpd_pkg::MODE_HAM6, 4'd8);
		push_pixel(1'b1, 8'h1a);
		push_pixel(1'b0, 8'h25);
		push_write(8'd2, 8'h0f, 8'hf0, 8'h3c, 1'b1, 8'h00);
		push_pixel(1'b0, 8'h3c);
		push_pixel(1'b0, 8'hcf);
		push_pixel(1'b0, 8'hff);

		apply_setting(hpd_pkg::MODE_HAM8, 4'd8);
		push_pixel(1'b0, 8'h3f);
		push_pixel(1'b0, 8'h7f);
		push_pixel(1'b0, 8'h80);
		push_pixel(1'b0, 8'hc1);
		push_pixel(1'b1, 8'hff);

		// The unused mode decodes as indexed; plane counts at the extremes.
		apply_setting(MODE_UNUSED, 4'd0);
		push_pixel(1'b0, 8'hab);
		apply_setting(MODE_UNUSED, 4'd15);
		push_pixel(1'b0, 8'hff);
		apply_setting(hpd_pkg::MODE_INDEXED, 4'd1);
		push_pixel(1'b0, 8'hff);
		apply_setting(hpd_pkg::MODE_INDEXED, 4'd4);
		push_pixel(1'b0, 8'h2f);

		for (int p = 0; p < 11; p++) begin
			apply_setting(phase_mode[p], phase_planes[p]);
			in_idle_on   = (p % 3 != 2) && (p != 4);
			out_stall_on = (p % 3 != 1) && (p != 4);
			if (p == 4) begin
				hold_req++;
			end
			row_left = 0;
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(3) == 0) begin
					push_random_write();
				end else begin
					first = 1'b0;
					if (row_left == 0) begin
						first    = 1'b1;
						row_left = $urandom_range(40, 4);
					end else begin
						row_left--;
					end
					if ($urandom_range(19) == 0) begin
						first = 1'b1;
					end
					push_pixel(first, pick_code());
				end
			end
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- ham_palette_pixel_decoder.f -----
hw/rtl/hpd_pkg.sv
hw/rtl/hpd_ram.sv
hw/rtl/hpd_lookup.sv
hw/rtl/hpd_colour.sv
hw/rtl/ham_palette_pixel_decoder.sv
dv/testbench.sv
